### rtl/bmh_pkg.sv
// Shared types, sizes, codes and helpers for the binary min-heap core.
// Used by the heap sequencer and the port checker.
// Has no dependencies of its own.
package bmh_pkg;

	// Heap size and the widths that follow from it
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	// Field widths
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 16;
	localparam int STS_W    = 2;

	// Stream data widths, padded to whole bytes
	localparam int IN_BITS  = CMD_W + KEY_W + PAY_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = KEY_W + PAY_W + CNT_W + STS_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Bit positions of the input fields
	localparam int IN_KEY_LSB = CMD_W;
	localparam int IN_PAY_LSB = CMD_W + KEY_W;

	// Bit positions of the result fields
	localparam int OUT_PAY_LSB = KEY_W;
	localparam int OUT_CNT_LSB = KEY_W + PAY_W;
	localparam int OUT_STS_LSB = KEY_W + PAY_W + CNT_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd3;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	// One heap entry as held in the store
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// Sequencer states, one-hot
	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_UP_RD  = 12'b0000_0000_0010,
		ST_UP_CMP = 12'b0000_0000_0100,
		ST_DN_RDL = 12'b0000_0000_1000,
		ST_DN_RDR = 12'b0000_0001_0000,
		ST_DN_CMP = 12'b0000_0010_0000,
		ST_EX_RD1 = 12'b0000_0100_0000,
		ST_EX_RD2 = 12'b0000_1000_0000,
		ST_EX_LD  = 12'b0001_0000_0000,
		ST_BLD_RD = 12'b0010_0000_0000,
		ST_BLD_LD = 12'b0100_0000_0000,
		ST_FIN    = 12'b1000_0000_0000
	} state_t;

	// Map a 1-based heap position onto a store address
	function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [CNT_W-1:0] pos);
		logic [CNT_W-1:0] d;
		d = pos - CNT_W'(1);
		return d[ADDR_W-1:0];
	endfunction

	// Pack one result for the output stream, first field lowest
	function automatic logic [OUT_W-1:0] pack_result(
		input entry_t           res,
		input logic [CNT_W-1:0] count,
		input logic [STS_W-1:0] status
	);
		return {{(OUT_W - OUT_BITS){1'b0}}, status, count, res.payload, res.key};
	endfunction

endpackage

### rtl/bmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; width and depth come from its parameters.
module bmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  logic [WIDTH-1:0]               wr_data,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	output logic [WIDTH-1:0]               rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/binary_min_heap_core.sv
// Binary min-heap core: insert, extract-min, unordered append and build.
// Refused commands and appends go straight to the result; insert sifts the new entry up, extract
// lifts the last entry into the root and sifts it down, and build sifts down each parent node
// from the last parent back to the root.
// One shared comparator and store read port; s_tready is high only while waiting for a command,
// and a stalled result holds the core. Async active-low reset empties the heap, store not cleared.
module binary_min_heap_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// command [1:0], new_key [33:2], new_payload [49:34], zero fill above
	input  logic [bmh_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// out_key [31:0], out_payload [47:32], entry_count [54:48], status [56:55], zero fill
	output logic [bmh_pkg::OUT_W-1:0] m_tdata
);

	localparam int CW = bmh_pkg::CNT_W;

	bmh_pkg::state_t              state_q;
	logic [bmh_pkg::CMD_W-1:0]    cmd_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                pos_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                best_pos_q;
	logic                         moved_q;
	logic                         right_ok_q;
	bmh_pkg::entry_t              cur_q;
	bmh_pkg::entry_t              best_q;
	bmh_pkg::entry_t              res_q;
	logic [bmh_pkg::STS_W-1:0]    status_q;
	logic                         m_tvalid_q;
	logic [bmh_pkg::OUT_W-1:0]    m_tdata_q;

	logic [bmh_pkg::CMD_W-1:0]    in_cmd;
	bmh_pkg::entry_t              in_entry;
	logic                         in_fire;
	logic                         full;

	logic [CW:0]                  left_w;
	logic [CW:0]                  right_w;
	logic                         left_ok;
	logic                         right_ok;
	logic [CW-1:0]                parent_w;
	logic [CW-1:0]                next_pos;

	logic                         ram_we;
	logic [bmh_pkg::ADDR_W-1:0]   ram_waddr;
	bmh_pkg::entry_t              ram_wdata;
	logic [bmh_pkg::ADDR_W-1:0]   ram_raddr;
	bmh_pkg::entry_t              ram_rdata;

	logic [bmh_pkg::KEY_W-1:0]    cmp_b;
	logic                         key_le;
	logic                         sel_right;

	// Unpack the input transaction
	assign in_cmd   = s_tdata[bmh_pkg::CMD_W-1:0];
	assign in_entry = '{key:     s_tdata[bmh_pkg::IN_KEY_LSB +: bmh_pkg::KEY_W],
	                    payload: s_tdata[bmh_pkg::IN_PAY_LSB +: bmh_pkg::PAY_W]};
	assign s_tready = (state_q == bmh_pkg::ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign full     = (count_q >= CW'(bmh_pkg::CAPACITY));
	assign next_pos = count_q + CW'(1);

	// Tree neighbours of the current hole
	assign left_w   = {pos_q, 1'b0};
	assign right_w  = left_w + (CW + 1)'(1);
	assign left_ok  = (left_w <= {1'b0, count_q});
	assign right_ok = (right_w <= {1'b0, count_q});
	assign parent_w = pos_q >> 1;

	// Shared key comparator: read data against the moving entry or the best so far
	assign cmp_b     = (state_q == bmh_pkg::ST_DN_CMP) ? best_q.key : cur_q.key;
	assign key_le    = (ram_rdata.key <= cmp_b);
	assign sel_right = right_ok_q && key_le;

	// Entry store read address
	always_comb begin
		unique case (state_q)
			bmh_pkg::ST_UP_RD:  ram_raddr = bmh_pkg::pos_to_addr(parent_w);
			bmh_pkg::ST_DN_RDL: ram_raddr = bmh_pkg::pos_to_addr(left_w[CW-1:0]);
			bmh_pkg::ST_DN_RDR: ram_raddr = bmh_pkg::pos_to_addr(right_w[CW-1:0]);
			bmh_pkg::ST_EX_RD1: ram_raddr = bmh_pkg::pos_to_addr(CW'(1));
			bmh_pkg::ST_EX_RD2: ram_raddr = bmh_pkg::pos_to_addr(count_q);
			bmh_pkg::ST_BLD_RD: ram_raddr = bmh_pkg::pos_to_addr(idx_q);
			default:            ram_raddr = '0;
		endcase
	end

	// Entry store write: store an appended entry, or fill the hole with the moving entry or a displaced one
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bmh_pkg::pos_to_addr(pos_q);
		ram_wdata = cur_q;
		unique case (state_q)
			bmh_pkg::ST_IDLE: begin
				if (in_fire && in_cmd == bmh_pkg::CMD_APPEND && !full) begin
					ram_we    = 1'b1;
					ram_waddr = bmh_pkg::pos_to_addr(next_pos);
					ram_wdata = in_entry;
				end
			end
			bmh_pkg::ST_UP_RD: begin
				ram_we = (pos_q == CW'(1));
			end
			bmh_pkg::ST_UP_CMP: begin
				ram_we = 1'b1;
				if (!key_le) begin
					ram_wdata = ram_rdata;
				end
			end
			bmh_pkg::ST_DN_RDL: begin
				ram_we = !left_ok;
			end
			bmh_pkg::ST_DN_CMP: begin
				ram_we = 1'b1;
				if (sel_right) begin
					ram_wdata = ram_rdata;
				end else if (moved_q) begin
					ram_wdata = best_q;
				end
			end
			default: ;
		endcase
	end

	bmh_ram #(
		.WIDTH ($bits(bmh_pkg::entry_t)),
		.DEPTH (bmh_pkg::CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bmh_pkg::ST_IDLE;
			cmd_q      <= bmh_pkg::CMD_INSERT;
			count_q    <= '0;
			pos_q      <= '0;
			idx_q      <= '0;
			best_pos_q <= '0;
			moved_q    <= 1'b0;
			right_ok_q <= 1'b0;
			cur_q      <= '0;
			best_q     <= '0;
			res_q      <= '0;
			status_q   <= bmh_pkg::STS_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// Drop the result once taken; the final state reloads the register itself
			if (m_tvalid_q && m_tready && state_q != bmh_pkg::ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				bmh_pkg::ST_IDLE: begin
					if (in_fire) begin
						cmd_q    <= in_cmd;
						cur_q    <= in_entry;
						res_q    <= '0;
						status_q <= bmh_pkg::STS_OK;
						unique case (in_cmd)
							bmh_pkg::CMD_INSERT, bmh_pkg::CMD_APPEND: begin
								if (full) begin
									status_q <= bmh_pkg::STS_FULL;
									state_q  <= bmh_pkg::ST_FIN;
								end else begin
									count_q <= next_pos;
									pos_q   <= next_pos;
									state_q <= (in_cmd == bmh_pkg::CMD_INSERT) ?
									           bmh_pkg::ST_UP_RD : bmh_pkg::ST_FIN;
								end
							end
							bmh_pkg::CMD_EXTRACT: begin
								if (count_q == '0) begin
									status_q <= bmh_pkg::STS_EMPTY;
									state_q  <= bmh_pkg::ST_FIN;
								end else begin
									state_q <= bmh_pkg::ST_EX_RD1;
								end
							end
							default: begin
								if (count_q < CW'(2)) begin
									state_q <= bmh_pkg::ST_FIN;
								end else begin
									idx_q   <= count_q >> 1;
									state_q <= bmh_pkg::ST_BLD_RD;
								end
							end
						endcase
					end
				end
				// Sift up: fetch the parent, then move it down or settle
				bmh_pkg::ST_UP_RD: begin
					state_q <= (pos_q == CW'(1)) ? bmh_pkg::ST_FIN : bmh_pkg::ST_UP_CMP;
				end
				bmh_pkg::ST_UP_CMP: begin
					if (!key_le) begin
						pos_q   <= parent_w;
						state_q <= bmh_pkg::ST_UP_RD;
					end else begin
						state_q <= bmh_pkg::ST_FIN;
					end
				end
				// Extract: take the root, lift the last entry into the hole
				bmh_pkg::ST_EX_RD1: begin
					state_q <= bmh_pkg::ST_EX_RD2;
				end
				bmh_pkg::ST_EX_RD2: begin
					res_q   <= ram_rdata;
					state_q <= bmh_pkg::ST_EX_LD;
				end
				bmh_pkg::ST_EX_LD: begin
					cur_q   <= ram_rdata;
					count_q <= count_q - CW'(1);
					pos_q   <= CW'(1);
					state_q <= (count_q == CW'(1)) ? bmh_pkg::ST_FIN : bmh_pkg::ST_DN_RDL;
				end
				// Build: load the next node and sift it down
				bmh_pkg::ST_BLD_RD: begin
					state_q <= bmh_pkg::ST_BLD_LD;
				end
				bmh_pkg::ST_BLD_LD: begin
					cur_q   <= ram_rdata;
					pos_q   <= idx_q;
					state_q <= bmh_pkg::ST_DN_RDL;
				end
				// Sift down: left child, right child, then pick the winner
				bmh_pkg::ST_DN_RDL: begin
					if (left_ok) begin
						state_q <= bmh_pkg::ST_DN_RDR;
					end else if (cmd_q == bmh_pkg::CMD_BUILD && idx_q > CW'(1)) begin
						idx_q   <= idx_q - CW'(1);
						state_q <= bmh_pkg::ST_BLD_RD;
					end else begin
						state_q <= bmh_pkg::ST_FIN;
					end
				end
				bmh_pkg::ST_DN_RDR: begin
					right_ok_q <= right_ok;
					best_pos_q <= left_w[CW-1:0];
					moved_q    <= key_le;
					best_q     <= key_le ? ram_rdata : cur_q;
					state_q    <= bmh_pkg::ST_DN_CMP;
				end
				bmh_pkg::ST_DN_CMP: begin
					if (sel_right) begin
						pos_q   <= right_w[CW-1:0];
						state_q <= bmh_pkg::ST_DN_RDL;
					end else if (moved_q) begin
						pos_q   <= best_pos_q;
						state_q <= bmh_pkg::ST_DN_RDL;
					end else if (cmd_q == bmh_pkg::CMD_BUILD && idx_q > CW'(1)) begin
						idx_q   <= idx_q - CW'(1);
						state_q <= bmh_pkg::ST_BLD_RD;
					end else begin
						state_q <= bmh_pkg::ST_FIN;
					end
				end
				// Hand the result over once the output register is free
				bmh_pkg::ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= bmh_pkg::pack_result(res_q, count_q, status_q);
						state_q    <= bmh_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bmh_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### rtl/bmh_checker.sv
// Port-level checker for the binary min-heap core, bound to the top level.
// Depends on bmh_pkg for field positions, codes and capacity.
module bmh_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [bmh_pkg::OUT_W-1:0] m_tdata
);

	logic [bmh_pkg::KEY_W-1:0] res_key;
	logic [bmh_pkg::PAY_W-1:0] res_pay;
	logic [bmh_pkg::CNT_W-1:0] res_cnt;
	logic [bmh_pkg::STS_W-1:0] res_sts;

	assign res_key = m_tdata[bmh_pkg::KEY_W-1:0];
	assign res_pay = m_tdata[bmh_pkg::OUT_PAY_LSB +: bmh_pkg::PAY_W];
	assign res_cnt = m_tdata[bmh_pkg::OUT_CNT_LSB +: bmh_pkg::CNT_W];
	assign res_sts = m_tdata[bmh_pkg::OUT_STS_LSB +: bmh_pkg::STS_W];

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Busy after every accepted command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while busy");

	// Count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_cnt <= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY))
		else $error("entry count above capacity");

	// A refused command returns no entry, and agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_sts == bmh_pkg::STS_EMPTY |->
		res_cnt == '0 && res_key == '0 && res_pay == '0)
		else $error("empty status inconsistent");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_sts == bmh_pkg::STS_FULL |->
		res_cnt == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY) && res_key == '0 && res_pay == '0)
		else $error("full status inconsistent");

endmodule

bind binary_min_heap_core bmh_checker u_bmh_checker (.*);
